// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define YM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");

// expression must never be true outside reset
`define YM_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition");

`else

`define YM_ASSERT(lbl, clk, rst_n, prop)
`define YM_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== sv/ymag_pkg.sv =====
// ----------------------------------------------------------------------------
// ymag_pkg
// shared types, codes and helpers of the yuv 4:2:0 mirror address generator
// ----------------------------------------------------------------------------
package ymag_pkg;

	localparam logic [12:0] MAX_WIDTH  = 13'd4096;
	localparam logic [12:0] MAX_HEIGHT = 13'd4096;

	// plane codes
	localparam logic [1:0] PLANE_Y = 2'd0;
	localparam logic [1:0] PLANE_U = 2'd1;
	localparam logic [1:0] PLANE_V = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_CHROMA_LAYOUT  = 2'd2;
	localparam logic [1:0] REG_FLIP_DIRECTION = 2'd3;

	// per-word address terms handed from the scan counters to the datapath
	typedef struct packed {
		logic [1:0]  plane;
		logic        half_stride;
		logic [11:0] row_t;
		logic [11:0] col_t;
		logic        last;
	} ymag_term_t;

	// clamp to 2..max and round down to even
	function automatic logic [12:0] eff_size(input logic [12:0] v, input logic [12:0] maxv);
		logic [12:0] t;
		t = v;
		if (t < 13'd2) t = 13'd2;
		if (t > maxv) t = maxv;
		return {t[12:1], 1'b0};
	endfunction

endpackage

// ===== sv/ymag_scan.sv =====
// ----------------------------------------------------------------------------
// ymag_scan
// plane, row, column and pair byte counters; derives the address terms
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ymag_scan import ymag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        restart,
	input  logic        step,
	input  logic [12:0] eff_w,
	input  logic [12:0] eff_h,
	input  logic        layout,
	input  logic        vert,
	output ymag_term_t  term
);

	logic [1:0]  plane_q;
	logic [11:0] row_q;
	logic [11:0] col_q;
	logic        sel_q;

	logic [11:0] cw;
	logic [11:0] ch;
	logic        is_luma;
	logic        pair_mode;
	logic [12:0] row_lim;
	logic [12:0] col_lim;
	logic [12:0] row_nx;
	logic [12:0] col_nx;
	logic        row_wrap;
	logic        col_wrap;
	logic        col_adv;
	logic [1:0]  plane_nx;
	logic [12:0] row_inv;
	logic [12:0] col_inv;
	logic [12:0] pair_inv;
	logic        at_frame_start;

	assign cw        = eff_w[12:1];
	assign ch        = eff_h[12:1];
	assign is_luma   = (plane_q == PLANE_Y);
	assign pair_mode = !is_luma && layout;
	assign row_lim   = is_luma ? eff_h : {1'b0, ch};
	assign col_lim   = is_luma ? eff_w : {1'b0, cw};
	assign row_nx    = {1'b0, row_q} + 13'd1;
	assign col_nx    = {1'b0, col_q} + 13'd1;
	assign row_wrap  = (row_nx == row_lim);
	assign col_wrap  = (col_nx == col_lim);
	assign col_adv   = !pair_mode || sel_q;

	always_comb begin
		case (plane_q)
			PLANE_Y: plane_nx = PLANE_U;
			PLANE_U: plane_nx = layout ? PLANE_Y : PLANE_V;
			default: plane_nx = PLANE_Y;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_Y;
			row_q   <= '0;
			col_q   <= '0;
			sel_q   <= 1'b0;
		end else if (restart) begin
			plane_q <= PLANE_Y;
			row_q   <= '0;
			col_q   <= '0;
			sel_q   <= 1'b0;
		end else if (step) begin
			if (!col_adv) begin
				sel_q <= 1'b1;
			end else begin
				sel_q <= 1'b0;
				if (col_wrap) begin
					col_q <= '0;
					if (row_wrap) begin
						row_q   <= '0;
						plane_q <= plane_nx;
					end else begin
						row_q <= row_nx[11:0];
					end
				end else begin
					col_q <= col_nx[11:0];
				end
			end
		end
	end

	// mirrored row and column terms
	assign row_inv  = row_lim - 13'd1 - {1'b0, row_q};
	assign col_inv  = col_lim - 13'd1 - {1'b0, col_q};
	assign pair_inv = eff_w - 13'd2 - {col_q, 1'b0};

	always_comb begin
		term.plane       = plane_q;
		term.half_stride = !is_luma && !layout;
		term.row_t       = vert ? row_inv[11:0] : row_q;
		if (pair_mode) begin
			term.col_t = vert ? {col_q[10:0], sel_q} : {pair_inv[11:1], sel_q};
		end else begin
			term.col_t = vert ? col_q : col_inv[11:0];
		end
		term.last = col_adv && col_wrap && row_wrap &&
			((plane_q == PLANE_V) || ((plane_q == PLANE_U) && layout));
	end

	assign at_frame_start = (plane_q == PLANE_Y) && (row_q == '0) && (col_q == '0) && !sel_q;

	`YM_NEVER(a_sel_in_luma, clk, arst_n, sel_q && (plane_q == PLANE_Y))
	`YM_NEVER(a_col_range, clk, arst_n, {1'b0, col_q} >= col_lim)
	`YM_NEVER(a_row_range, clk, arst_n, {1'b0, row_q} >= row_lim)
	`YM_ASSERT(a_last_wraps, clk, arst_n, (step && term.last) |=> at_frame_start)

endmodule

// ===== sv/yuv420_mirror_address_gen.sv =====
// ----------------------------------------------------------------------------
// yuv420_mirror_address_gen
// destination address of every byte of a mirrored or flipped yuv 4:2:0 frame
// ----------------------------------------------------------------------------
// pipeline: input register, then the 12x13 multiply and adder, then the result register
// throughput: one word per cycle unless the output stalls; the scan counters step per word
// a word is taken while a finished result waits, as long as the input register is free
// reset: asynchronous, active low; registers return to 640x480, planar, horizontal mirror
// any configuration write restarts the frame at the first luma byte
module yuv420_mirror_address_gen import ymag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] src_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [24:0] dest_addr, [32:25] dst_byte, [39:33] zero
	output logic        m_tlast    // frame_last
);

	logic [12:0] width_q;
	logic [12:0] height_q;
	logic        layout_q;
	logic        vert_q;

	logic [12:0] eff_w;
	logic [12:0] eff_h;
	logic [25:0] area;
	logic [24:0] len_q;
	logic [24:0] vbase_q;

	ymag_term_t  term;
	ymag_term_t  term_s1;
	logic [7:0]  byte_s1;
	logic        valid_s1;

	logic        adv_out;
	logic        adv_s1;
	logic        accept;

	logic [12:0] stride;
	logic [24:0] prod;
	logic [24:0] base;
	logic [24:0] addr;

	logic        out_valid_q;
	logic [24:0] addr_q;
	logic [7:0]  byte_q;
	logic        last_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd640;
			height_q <= 13'd480;
			layout_q <= 1'b0;
			vert_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FRAME_WIDTH:    width_q  <= cfg_wdata;
				REG_FRAME_HEIGHT:   height_q <= cfg_wdata;
				REG_CHROMA_LAYOUT:  layout_q <= cfg_wdata[0];
				REG_FLIP_DIRECTION: vert_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign eff_w = eff_size(width_q, MAX_WIDTH);
	assign eff_h = eff_size(height_q, MAX_HEIGHT);
	assign area  = eff_w * eff_h;

	// plane base offsets
	always_ff @(posedge clk) begin
		len_q   <= area[24:0];
		vbase_q <= len_q + {2'b00, len_q[24:2]};
	end

	// handshake
	assign adv_out  = !out_valid_q || m_tready;
	assign adv_s1   = !valid_s1 || adv_out;
	assign s_tready = adv_s1;
	assign accept   = s_tvalid && s_tready;

	ymag_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.step    (accept),
		.eff_w   (eff_w),
		.eff_h   (eff_h),
		.layout  (layout_q),
		.vert    (vert_q),
		.term    (term)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			term_s1 <= term;
			byte_s1 <= s_tdata;
		end
	end

	// address datapath
	assign stride = term_s1.half_stride ? {1'b0, eff_w[12:1]} : eff_w;
	assign prod   = term_s1.row_t * stride;

	always_comb begin
		case (term_s1.plane)
			PLANE_U: base = len_q;
			PLANE_V: base = vbase_q;
			default: base = '0;
		endcase
	end

	assign addr = base + prod + {13'd0, term_s1.col_t};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			addr_q <= addr;
			byte_q <= byte_s1;
			last_q <= term_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, byte_q, addr_q};
	assign m_tlast  = last_q;

endmodule

// ===== sim/ymag_checker.sv =====
// ----------------------------------------------------------------------------
// ymag_checker
// watches the register port and both streams of the yuv 4:2:0 mirror
// address generator, works out where each accepted byte must land in the
// mirrored frame and compares every result word with the oldest prediction
// ----------------------------------------------------------------------------
module ymag_checker import ymag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] src_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [24:0] dest_addr, [32:25] dst_byte, [39:33] zero
	input  logic        m_tlast,   // frame_last
	output int          errors,
	output int          pending,
	output int          frames_done
);

	typedef struct packed {
		logic [24:0] dest;
		logic [7:0]  data;
		logic        last;
	} placed_word_t;

	logic [12:0]  cfg_w     = 13'd640;
	logic [12:0]  cfg_h     = 13'd480;
	logic         cfg_pairs = 1'b0;
	logic         cfg_vflip = 1'b0;

	logic [1:0]   cur_plane = PLANE_Y;
	logic [11:0]  cur_row   = '0;
	logic [11:0]  cur_col   = '0;
	logic         cur_half  = 1'b0;

	placed_word_t placed_q[$];
	int           err_tally   = 0;
	int           frame_tally = 0;

	function automatic int unsigned fit_size(input logic [12:0] v, input logic [12:0] lim);
		int unsigned t;
		t = v;
		if (t < 2) t = 2;
		if (t > lim) t = lim;
		return t & ~32'd1;
	endfunction

	// destination of the next source byte; advances the scan position
	function automatic placed_word_t place_byte(input logic [7:0] b);
		int unsigned w, h, cw, ch, len, base, r, c, a;
		logic closes;
		w = fit_size(cfg_w, MAX_WIDTH);
		h = fit_size(cfg_h, MAX_HEIGHT);
		cw = w >> 1;
		ch = h >> 1;
		len = w * h;
		r = cur_row;
		c = cur_col;
		closes = 1'b0;
		if (cur_plane == PLANE_Y) begin
			if (r >= h) r = h - 1;
			if (c >= w) c = w - 1;
			a = cfg_vflip ? (h - 1 - r) * w + c : r * w + (w - 1 - c);
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h) begin
					r = 0;
					cur_plane = PLANE_U;
				end
			end
		end else if (cfg_pairs) begin
			if (r >= ch) r = ch - 1;
			if (c >= cw) c = cw - 1;
			a = len + (cfg_vflip ? (ch - 1 - r) * w + 2 * c : r * w + 2 * (cw - 1 - c))
				+ cur_half;
			if (!cur_half) begin
				cur_half = 1'b1;
			end else begin
				cur_half = 1'b0;
				c++;
				if (c >= cw) begin
					c = 0;
					r++;
					if (r >= ch) begin
						r = 0;
						cur_plane = PLANE_Y;
						closes = 1'b1;
					end
				end
			end
		end else begin
			base = (cur_plane == PLANE_U) ? len : len + (len >> 2);
			if (r >= ch) r = ch - 1;
			if (c >= cw) c = cw - 1;
			a = base + (cfg_vflip ? (ch - 1 - r) * cw + c : r * cw + (cw - 1 - c));
			c++;
			if (c >= cw) begin
				c = 0;
				r++;
				if (r >= ch) begin
					r = 0;
					if (cur_plane == PLANE_U) begin
						cur_plane = PLANE_V;
					end else begin
						cur_plane = PLANE_Y;
						closes = 1'b1;
					end
				end
			end
		end
		cur_row = r[11:0];
		cur_col = c[11:0];
		return '{dest: a[24:0], data: b, last: closes};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		placed_word_t want;
		if (!arst_n) begin
			cfg_w = 13'd640;
			cfg_h = 13'd480;
			cfg_pairs = 1'b0;
			cfg_vflip = 1'b0;
			cur_plane = PLANE_Y;
			cur_row = '0;
			cur_col = '0;
			cur_half = 1'b0;
			placed_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_FRAME_WIDTH: cfg_w = cfg_wdata;
					REG_FRAME_HEIGHT: cfg_h = cfg_wdata;
					REG_CHROMA_LAYOUT: cfg_pairs = cfg_wdata[0];
					REG_FLIP_DIRECTION: cfg_vflip = cfg_wdata[0];
					default: ;
				endcase
				// any write restarts the frame
				cur_plane = PLANE_Y;
				cur_row = '0;
				cur_col = '0;
				cur_half = 1'b0;
			end
			if (s_tvalid && s_tready)
				placed_q.push_back(place_byte(s_tdata));
			if (m_tvalid && m_tready) begin
				if (m_tlast)
					frame_tally++;
				if (placed_q.size() == 0) begin
					err_tally++;
					if (err_tally <= 10)
						$display("ymag_checker: unpredicted word a=%0d b=%02h l=%0b t=%0t",
							m_tdata[24:0], m_tdata[32:25], m_tlast, $time);
				end else begin
					want = placed_q.pop_front();
					if (m_tdata[24:0] !== want.dest || m_tdata[32:25] !== want.data ||
						m_tdata[39:33] !== 7'd0 || m_tlast !== want.last) begin
						err_tally++;
						if (err_tally <= 10)
							$display("ymag_checker: exp a=%0d b=%02h l=%0b, %s%0d b=%02h l=%0b %s%02h t=%0t",
								want.dest, want.data, want.last, "got a=", m_tdata[24:0],
								m_tdata[32:25], m_tlast, "pad=", m_tdata[39:33], $time);
					end
				end
			end
		end
		errors <= err_tally;
		pending <= placed_q.size();
		frames_done <= frame_tally;
	end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// streams yuv 4:2:0 frame bytes through the mirror address generator under
// many frame sizes, both chroma layouts and both flip directions, with bursty
// input and a stalling output; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_top;
	import ymag_pkg::*;

	localparam int ITEM_TARGET = 1100;
	localparam int STALL_LIMIT = 2000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_addr  = REG_FRAME_WIDTH;
	logic [12:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] src_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;          // [24:0] dest_addr, [32:25] dst_byte, [39:33] zero
	logic        m_tlast;          // frame_last

	int errors;
	int pending;
	int frames_done;
	int sent        = 0;
	int settings    = 0;
	int burst_left  = 0;
	int idle_cycles = 0;
	int rdy_left    = 0;
	logic [1:0] rdy_mode = 2'd0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	yuv420_mirror_address_gen dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	ymag_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.errors      (errors),
		.pending     (pending),
		.frames_done (frames_done)
	);

	// receiver: ready pattern switches at random between four modes
	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode <= 2'($urandom_range(0, 3));
			rdy_left <= $urandom_range(16, 80);
		end else begin
			rdy_left <= rdy_left - 1;
		end
		case (rdy_mode)
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= (rdy_left % 4 == 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top: no word moved for %0d cycles", STALL_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [12:0] raw_w, input logic [12:0] raw_h,
		input logic pairs, input logic vflip);
		write_reg(REG_FRAME_WIDTH, raw_w);
		write_reg(REG_FRAME_HEIGHT, raw_h);
		write_reg(REG_CHROMA_LAYOUT, {12'($urandom_range(0, 4095)), pairs});
		write_reg(REG_FLIP_DIRECTION, {12'($urandom_range(0, 4095)), vflip});
		settings++;
	endtask

	// one word on the input side; bursts end in a random gap, sometimes none
	task automatic send_word(input logic [7:0] b);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(0, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait until every predicted word is out, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register value for an even size: exact, odd, below 2 or above the maximum
	function automatic logic [12:0] raw_size(input int e);
		case ($urandom_range(0, 3))
			0: return 13'(e + 1);
			1: begin
				if (e == 2)
					return 13'($urandom_range(0, 1));
				else if (e == 4096)
					return 13'($urandom_range(4097, 8191));
				else
					return 13'(e);
			end
			default: return 13'(e);
		endcase
	endfunction

	initial begin
		int ew, eh, fbytes, nbytes;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: 640x480 planar, horizontal mirror
		send_word(8'h00);
		send_word(8'hff);
		drain();
		// oversized registers clamp to 4096, vertical flip gives the top addresses
		set_frame(13'd8191, 13'd8191, 1'b0, 1'b1);
		send_word(8'hff);
		send_word(8'h00);
		drain();
		// undersized and odd sizes collapse to 2x2; whole frames in every mode
		set_frame(13'd1, 13'd0, 1'b1, 1'b0);
		repeat (6) send_word(8'($urandom_range(0, 255)));
		drain();
		set_frame(13'd3, 13'd2, 1'b0, 1'b1);
		repeat (6) send_word(8'($urandom_range(0, 255)));
		drain();
		set_frame(13'd2, 13'd3, 1'b1, 1'b1);
		repeat (6) send_word(8'($urandom_range(0, 255)));
		drain();
		set_frame(13'd2, 13'd2, 1'b0, 1'b0);
		repeat (6) send_word(8'($urandom_range(0, 255)));
		drain();

		while (sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: begin
					// frame of random size up to 4096x4096, only its first bytes
					ew = ($urandom_range(0, 1) != 0) ? 4096 : 2 * $urandom_range(1, 2048);
					eh = ($urandom_range(0, 1) != 0) ? 4096 : 2 * $urandom_range(1, 2048);
					nbytes = $urandom_range(1, 60);
				end
				1: begin
					// wide strip, one whole frame
					ew = 2 * $urandom_range(9, 64);
					eh = 2;
					nbytes = ew * eh * 3 / 2;
				end
				default: begin
					ew = 2 * $urandom_range(1, 8);
					eh = 2 * $urandom_range(1, 6);
					fbytes = ew * eh * 3 / 2;
					nbytes = fbytes * $urandom_range(1, 3);
					// cut the last frame short now and then
					if ($urandom_range(0, 3) == 0)
						nbytes -= $urandom_range(1, fbytes - 1);
				end
			endcase
			// keep the total near the target
			if (nbytes > ITEM_TARGET - sent)
				nbytes = ITEM_TARGET - sent;
			set_frame(raw_size(ew), raw_size(eh), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			repeat (nbytes) send_word(8'($urandom_range(0, 255)));
			drain();
		end

		repeat (8) @(posedge clk);
		$display("tb_top: %0d bytes streamed under %0d register settings, %0d frames closed",
			sent, settings, frames_done);
		$display("tb_top: %0d mismatched words, %0d predicted words never seen", errors, pending);
		if (errors == 0 && pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
